>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked assertion with reset disable.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bns_pkg.sv
// Package with types and constants of the BER nesting scanner.
package bns_pkg;

    localparam int unsigned LEN_BITS = 64;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_TAG     = 3'd1,
        PH_TAGMORE = 3'd2,
        PH_LEN     = 3'd3,
        PH_LENLONG = 3'd4,
        PH_CONTENT = 3'd5,
        PH_EOC2    = 3'd6,
        PH_SETTLE  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_SHORT   = 3'd1,
        ST_BADLEN  = 3'd2,
        ST_BADTAG  = 3'd3,
        ST_TAGLONG = 3'd4,
        ST_DEPTH   = 3'd5
    } status_t;

    typedef enum logic [0:0] {
        REG_REGION_SIZE = 1'b0,
        REG_OUTER_INDEF = 1'b1
    } reg_index_t;

    // One queued byte handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } byte_entry_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] value_len;
        logic [31:0] consumed;
    } result_t;

endpackage

>>> hdl/bns_stream_if.sv
// Valid/ready channel interface with a generic payload.
interface bns_stream_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/bns_front.sv
// Input queue that decouples byte acceptance from the scan engine.
module bns_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bns_pkg::byte_entry_t in_entry,
    output logic                 q_valid,
    input  logic                 q_ready,
    output bns_pkg::byte_entry_t q_entry
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bns_pkg::byte_entry_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          push, pop;

    assign in_ready = (count_reg != (AW+1)'(DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_entry  = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end
endmodule

>>> hdl/bns_engine.sv
// Scan engine: walks queued bytes, keeps the nesting stack, emits results.
module bns_engine #(
    parameter int unsigned MAX_DEPTH      = 16,
    parameter int unsigned TAG_MAX_OCTETS = 8,
    parameter int unsigned POS_BITS       = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [31:0]          region_size,
    input  logic                 outer_indefinite,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  bns_pkg::byte_entry_t q_entry,
    output logic                 res_valid,
    input  logic                 res_ready,
    output bns_pkg::result_t     res_data
);
    localparam int unsigned LVW = $clog2(MAX_DEPTH + 1);
    localparam int unsigned SPW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int unsigned TCW = $clog2(TAG_MAX_OCTETS + 1);

    logic [POS_BITS-1:0] end_mem [MAX_DEPTH];
    logic                indef_mem [MAX_DEPTH];

    bns_pkg::phase_t     phase_reg, phase_next;
    logic [LVW-1:0]      level_reg, level_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [TCW-1:0]      tagcnt_reg, tagcnt_next;
    logic [6:0]          lenleft_reg, lenleft_next;
    logic [63:0]         acc_reg, acc_next;
    logic [POS_BITS-1:0] content_reg, content_next;
    logic                cons_reg, cons_next;
    logic                started_reg, started_next;
    logic                res_valid_reg, res_valid_next;
    bns_pkg::result_t    res_reg, res_next;

    logic                push_en;
    logic [SPW-1:0]      push_idx;
    logic [POS_BITS-1:0] push_end;
    logic                push_indef;

    // Top-of-stack view; level zero reads as the current position.
    logic [SPW-1:0]      top_idx;
    logic [POS_BITS-1:0] top_end;
    logic                top_indef;
    logic [POS_BITS-1:0] limit;
    logic [POS_BITS-1:0] room;
    logic [POS_BITS-1:0] pos_inc;
    logic [7:0]          b;
    logic                take;
    logic [POS_BITS-1:0] region_cut;
    logic [63:0]         len_val;

    assign top_idx   = SPW'(level_reg - 1'b1);
    assign top_end   = end_mem[top_idx];
    assign top_indef = indef_mem[top_idx];
    assign limit     = (level_reg == '0) ? pos_reg : top_end;
    assign room      = limit - pos_reg;
    assign pos_inc   = pos_reg + 1'b1;
    assign b         = q_entry.data_byte;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    always_comb
    begin
        if (POS_BITS >= 32)
        begin
            region_cut = POS_BITS'(region_size);
        end
        else
        begin
            region_cut = region_size[POS_BITS-1:0];
        end
    end

    // Settle and start are done in separate cycles, so a byte is only taken
    // in a byte-consuming phase and when the result slot is free.
    always_comb
    begin
        phase_next     = phase_reg;
        level_next     = level_reg;
        pos_next       = pos_reg;
        tagcnt_next    = tagcnt_reg;
        lenleft_next   = lenleft_reg;
        acc_next       = acc_reg;
        content_next   = content_reg;
        cons_next      = cons_reg;
        started_next   = started_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        push_en        = 1'b0;
        push_idx       = SPW'(level_reg);
        push_end       = '0;
        push_indef     = 1'b0;
        len_val        = '0;
        q_ready        = 1'b0;
        take           = 1'b0;

        if (!res_valid_next)
        begin
            if (phase_reg == bns_pkg::PH_SETTLE)
            begin
                if (level_reg != '0 && pos_reg == top_end)
                begin
                    if (top_indef)
                    begin
                        phase_next        = bns_pkg::PH_IDLE;
                        res_valid_next    = 1'b1;
                        res_next.status   = bns_pkg::ST_SHORT;
                        res_next.value_len = '0;
                        res_next.consumed = '0;
                    end
                    else
                    begin
                        level_next = level_reg - 1'b1;
                        if (level_reg == LVW'(1))
                        begin
                            phase_next        = bns_pkg::PH_IDLE;
                            res_valid_next    = 1'b1;
                            res_next.status   = bns_pkg::ST_OK;
                            res_next.value_len = 32'(pos_reg);
                            res_next.consumed = 32'(pos_reg);
                        end
                    end
                end
                else
                begin
                    phase_next = bns_pkg::PH_TAG;
                end
                // An empty region ends at once and its start byte is dropped.
                if (res_valid_next && started_reg)
                begin
                    q_ready      = q_valid;
                    started_next = 1'b0;
                end
            end
            else if (q_valid)
            begin
                if (q_entry.start_req && !started_reg)
                begin
                    // Restart: set up the outer level, then reprocess this byte
                    // after the settle pass as a fresh start-free byte.
                    started_next = 1'b1;
                    level_next   = LVW'(1);
                    pos_next     = '0;
                    tagcnt_next  = '0;
                    lenleft_next = '0;
                    acc_next     = '0;
                    content_next = '0;
                    cons_next    = 1'b0;
                    push_en      = 1'b1;
                    push_idx     = '0;
                    push_end     = region_cut;
                    push_indef   = outer_indefinite;
                    phase_next   = bns_pkg::PH_SETTLE;
                end
                else
                begin
                    q_ready      = 1'b1;
                    started_next = 1'b0;
                    take         = 1'b1;
                end
            end
        end

        if (take)
        begin
            case (phase_reg)
                bns_pkg::PH_TAG:
                begin
                    if (b == 8'h00)
                    begin
                        if (room < POS_BITS'(2))
                        begin
                            res_valid_next = 1'b1;
                            res_next.status = bns_pkg::ST_SHORT;
                        end
                        else
                        begin
                            pos_next   = pos_inc;
                            phase_next = bns_pkg::PH_EOC2;
                        end
                    end
                    else if (b == 8'h20)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_BADTAG;
                    end
                    else
                    begin
                        cons_next   = b[5];
                        tagcnt_next = TCW'(1);
                        pos_next    = pos_inc;
                        if (pos_inc == limit)
                        begin
                            res_valid_next  = 1'b1;
                            res_next.status = bns_pkg::ST_SHORT;
                        end
                        else
                        begin
                            phase_next = (b[4:0] == 5'h1F) ? bns_pkg::PH_TAGMORE
                                                           : bns_pkg::PH_LEN;
                        end
                    end
                end
                bns_pkg::PH_TAGMORE:
                begin
                    tagcnt_next = tagcnt_reg + 1'b1;
                    if (tagcnt_next == TCW'(2) && b[6:0] == 7'h00)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_BADTAG;
                    end
                    else if (b[7] && tagcnt_next >= TCW'(TAG_MAX_OCTETS))
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_TAGLONG;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                        if (pos_inc == limit)
                        begin
                            res_valid_next  = 1'b1;
                            res_next.status = bns_pkg::ST_SHORT;
                        end
                        else
                        begin
                            phase_next = b[7] ? bns_pkg::PH_TAGMORE : bns_pkg::PH_LEN;
                        end
                    end
                end
                bns_pkg::PH_LEN:
                begin
                    pos_next = pos_inc;
                    if (b == 8'h80)
                    begin
                        if (!cons_reg)
                        begin
                            res_valid_next  = 1'b1;
                            res_next.status = bns_pkg::ST_BADLEN;
                        end
                        else if (level_reg >= LVW'(MAX_DEPTH))
                        begin
                            res_valid_next  = 1'b1;
                            res_next.status = bns_pkg::ST_DEPTH;
                        end
                        else
                        begin
                            push_en    = 1'b1;
                            push_end   = limit;
                            push_indef = 1'b1;
                            level_next = level_reg + 1'b1;
                            phase_next = bns_pkg::PH_SETTLE;
                        end
                    end
                    else if (b == 8'hFF)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_BADLEN;
                    end
                    else if (!b[7])
                    begin
                        len_val = 64'(b);
                    end
                    else
                    begin
                        lenleft_next = b[6:0];
                        if (POS_BITS'(b[6:0]) > limit - pos_inc ||
                            (POS_BITS < 7 && |(b[6:0] >> POS_BITS)))
                        begin
                            res_valid_next  = 1'b1;
                            res_next.status = bns_pkg::ST_SHORT;
                        end
                        else
                        begin
                            acc_next   = '0;
                            phase_next = bns_pkg::PH_LENLONG;
                        end
                    end
                end
                bns_pkg::PH_LENLONG:
                begin
                    if (acc_reg[63:56] != 8'h00)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_BADLEN;
                    end
                    else
                    begin
                        acc_next = {acc_reg[55:0], b};
                        pos_next = pos_inc;
                        if (lenleft_reg != '0)
                        begin
                            lenleft_next = lenleft_reg - 1'b1;
                        end
                        if (lenleft_next == '0)
                        begin
                            len_val = acc_next;
                        end
                    end
                end
                bns_pkg::PH_CONTENT:
                begin
                    pos_next = pos_inc;
                    if (content_reg != '0)
                    begin
                        content_next = content_reg - 1'b1;
                    end
                    if (content_next == '0)
                    begin
                        phase_next = bns_pkg::PH_SETTLE;
                    end
                end
                bns_pkg::PH_EOC2:
                begin
                    if (b != 8'h00)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_BADLEN;
                    end
                    else if (level_reg == '0 || !top_indef)
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_BADTAG;
                    end
                    else
                    begin
                        level_next = level_reg - 1'b1;
                        if (level_reg == LVW'(1))
                        begin
                            res_valid_next      = 1'b1;
                            res_next.status     = bns_pkg::ST_OK;
                            res_next.value_len  = 32'(pos_reg - 1'b1);
                            res_next.consumed   = 32'(pos_inc);
                        end
                        else
                        begin
                            pos_next   = pos_inc;
                            phase_next = bns_pkg::PH_SETTLE;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Length complete: check room against the level, then open or skip.
            if (!res_valid_next &&
                ((phase_reg == bns_pkg::PH_LEN && !b[7]) ||
                 (phase_reg == bns_pkg::PH_LENLONG && lenleft_next == '0)))
            begin
                if (len_val > 64'(limit - pos_next))
                begin
                    res_valid_next  = 1'b1;
                    res_next.status = bns_pkg::ST_SHORT;
                end
                else if (cons_reg)
                begin
                    if (level_reg >= LVW'(MAX_DEPTH))
                    begin
                        res_valid_next  = 1'b1;
                        res_next.status = bns_pkg::ST_DEPTH;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        push_end   = pos_next + POS_BITS'(len_val);
                        push_indef = 1'b0;
                        level_next = level_reg + 1'b1;
                        phase_next = bns_pkg::PH_SETTLE;
                    end
                end
                else if (len_val == '0)
                begin
                    phase_next = bns_pkg::PH_SETTLE;
                end
                else
                begin
                    content_next = POS_BITS'(len_val);
                    phase_next   = bns_pkg::PH_CONTENT;
                end
            end

            if (res_valid_next)
            begin
                phase_next = bns_pkg::PH_IDLE;
                if (res_next.status != bns_pkg::ST_OK || !(phase_reg == bns_pkg::PH_EOC2))
                begin
                    if (res_next.status != bns_pkg::ST_OK)
                    begin
                        res_next.value_len = '0;
                        res_next.consumed  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= bns_pkg::PH_IDLE;
            level_reg     <= '0;
            pos_reg       <= '0;
            tagcnt_reg    <= '0;
            lenleft_reg   <= '0;
            acc_reg       <= '0;
            content_reg   <= '0;
            cons_reg      <= 1'b0;
            started_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            pos_reg       <= pos_next;
            tagcnt_reg    <= tagcnt_next;
            lenleft_reg   <= lenleft_next;
            acc_reg       <= acc_next;
            content_reg   <= content_next;
            cons_reg      <= cons_next;
            started_reg   <= started_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (push_en)
        begin
            end_mem[push_idx]   <= push_end;
            indef_mem[push_idx] <= push_indef;
        end
    end
endmodule

>>> hdl/ber_nesting_scanner.sv
// Top level of the BER nesting scanner.
// Input channel in_ch carries one byte of a BER region per transaction with
// start_req marking the first byte of a new scan. Output channel out_ch carries
// one result transaction per finished scan: status, value_len and consumed.
// Registers region_size (address 0) and outer_indefinite (address 4) are set
// through the APB port and latched at each start; the user must set them only
// while the block is idle, as the block itself does not enforce this.
// Bytes enter a two-entry queue; the scan engine takes one byte per cycle in
// most phases while no result waits. A start byte first sets up the outer
// level and then runs a settle pass, and at every element boundary a settle
// pass closes each nesting level that ends there, one level at a time.
// A result is registered onto out_ch when its scan ends and is held until
// taken; while it waits the engine stalls and the queue fills, which in turn
// drops in_ch.ready. Bytes arriving after a scan ends and before the next
// start are consumed without a result.
// Reset clears the queue, the engine state and the registers to
// region_size 1 and outer_indefinite 0.
module ber_nesting_scanner #(
    parameter int unsigned MAX_DEPTH      = 16,
    parameter int unsigned TAG_MAX_OCTETS = 8,
    parameter int unsigned POS_BITS       = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    bns_stream_if.sink   in_ch,
    bns_stream_if.source out_ch,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [31:0]          region_size_reg;
    logic                 outer_indef_reg;
    logic                 q_valid, q_ready;
    bns_pkg::byte_entry_t q_entry;
    logic                 wr_en;
    bns_pkg::reg_index_t  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = bns_pkg::reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= 32'd1;
            outer_indef_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bns_pkg::REG_REGION_SIZE: region_size_reg <= pwdata;
                bns_pkg::REG_OUTER_INDEF: outer_indef_reg <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            bns_pkg::REG_REGION_SIZE: prdata = region_size_reg;
            bns_pkg::REG_OUTER_INDEF: prdata = {31'd0, outer_indef_reg};
            default:                  prdata = '0;
        endcase
    end

    bns_front #(
        .DEPTH(2)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_ch.valid),
        .in_ready(in_ch.ready),
        .in_entry(in_ch.payload),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry)
    );

    bns_engine #(
        .MAX_DEPTH     (MAX_DEPTH),
        .TAG_MAX_OCTETS(TAG_MAX_OCTETS),
        .POS_BITS      (POS_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .region_size     (region_size_reg),
        .outer_indefinite(outer_indef_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_entry         (q_entry),
        .res_valid       (out_ch.valid),
        .res_ready       (out_ch.ready),
        .res_data        (out_ch.payload)
    );
endmodule

>>> hdl/bns_checker.sv
// Port-level checker for the BER nesting scanner, bound to the top level.
`include "assert_macros.svh"

module bns_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_ready,
    input logic [2:0]   out_status,
    input logic [31:0]  out_value_len,
    input logic [31:0]  out_consumed,
    input logic         pready
);
    logic status_in_range;
    logic res_ok;
    logic res_err;
    logic sizes_zero;
    logic stalled;

    assign status_in_range = (out_status <= bns_pkg::ST_DEPTH);
    assign res_ok          = out_valid && (out_status == bns_pkg::ST_OK);
    assign res_err         = out_valid && (out_status != bns_pkg::ST_OK);
    assign sizes_zero      = (out_value_len == 32'd0) && (out_consumed == 32'd0);
    assign stalled         = out_valid && !out_ready;

    `CHK_ASSERT(a_status_range, clk, rst_n, out_valid |-> status_in_range, "status out of range")
    `CHK_ASSERT(a_err_zero, clk, rst_n, res_err |-> sizes_zero, "error result carries sizes")
    `CHK_ASSERT(a_ok_sizes, clk, rst_n, res_ok |-> (out_value_len <= out_consumed), "size order")
    `CHK_ASSERT(a_hold, clk, rst_n, stalled |=> (out_valid && $stable(out_status)), "held result")
    `CHK_ASSERT_ALWAYS(a_pready, clk, pready, "pready must stay high")
endmodule

bind ber_nesting_scanner bns_checker u_bns_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_status   (out_ch.payload.status),
    .out_value_len(out_ch.payload.value_len),
    .out_consumed (out_ch.payload.consumed),
    .pready       (pready)
);
